>>> rtl/camr_pkg.sv
// Package with shared constants, types and helpers for the mesh router.
package camr_pkg;

  localparam int unsigned MeshRowsDef = 4;
  localparam int unsigned MeshColsDef = 4;
  localparam int unsigned LoadBitsDef = 8;
  localparam int unsigned CostBits    = 16;
  localparam logic [CostBits-1:0] CostMax = '1;

  localparam logic [2:0] PortLocal = 3'd0;
  localparam logic [2:0] PortNorth = 3'd1;
  localparam logic [2:0] PortSouth = 3'd2;
  localparam logic [2:0] PortEast  = 3'd3;
  localparam logic [2:0] PortWest  = 3'd4;

  localparam logic KindLoad  = 1'b0;
  localparam logic KindRoute = 1'b1;

  // One queued word between the front and the back.
  typedef struct packed {
    logic       kind;
    logic [7:0] load_tile;
    logic [7:0] load_value;
    logic [7:0] dest_tile;
  } cmd_t;

  typedef enum logic [2:0] {
    StIdle, StInit, StSweep, StPick, StOut
  } state_e;

  function automatic logic [CostBits-1:0] sat_add(input logic [CostBits-1:0] a,
                                                  input logic [CostBits-1:0] b);
    logic [CostBits:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CostBits] ? CostMax : s[CostBits-1:0];
  endfunction

endpackage

>>> rtl/camr_cmd_fifo.sv
// Two-entry command queue between the front end and the relaxation engine.
module camr_cmd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  camr_pkg::cmd_t  data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output camr_pkg::cmd_t  data_o
);
  import camr_pkg::*;

  cmd_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i && !full_o) wptr_q <= ~wptr_q;
      if (pop_i && !empty_o) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'((push_i && !full_o) ? 1 : 0) - 2'((pop_i && !empty_o) ? 1 : 0);
    end
  end
endmodule

>>> rtl/camr_engine.sv
// Load table and iterative Bellman-Ford relaxation engine, one tile per cycle.
module camr_engine #(
  parameter int unsigned MeshRows = camr_pkg::MeshRowsDef,
  parameter int unsigned MeshCols = camr_pkg::MeshColsDef,
  parameter int unsigned LoadBits = camr_pkg::LoadBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [7:0]                 router_tile_i,
  input  logic                       cmd_empty_i,
  input  camr_pkg::cmd_t             cmd_i,
  output logic                       cmd_pop_o,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output logic [2:0]                 next_port_o,
  output logic [camr_pkg::CostBits-1:0] path_cost_o
);
  import camr_pkg::*;

  localparam int unsigned Tiles = MeshRows * MeshCols;
  localparam int unsigned TW = $clog2(Tiles);
  localparam int unsigned RW = $clog2(MeshRows);
  localparam int unsigned CW = $clog2(MeshCols);
  localparam logic [LoadBits-1:0] LoadMax = '1;

  state_e state_q, state_d;
  logic [LoadBits-1:0] load_q [Tiles];
  logic [CostBits-1:0] cost_q [Tiles];
  logic [Tiles-1:0]    cvalid_q;
  logic [TW-1:0]       dest_q, t_q;
  logic [RW-1:0]       r_q;
  logic [CW-1:0]       c_q;
  logic                changed_q;
  logic [2:0]          port_q;
  logic [CostBits-1:0] pcost_q;

  logic                have;
  logic [CostBits-1:0] best, cand;
  logic [TW-1:0]       nt;
  logic [TW-1:0]       pnt;
  logic                upd;
  logic [LoadBits-1:0] lv_sat;
  logic                route_ok;
  logic [RW-1:0]       xr;
  logic [CW-1:0]       xc;
  logic                p_have;
  logic [CostBits-1:0] p_best;
  logic [2:0]          p_sel;
  logic                last_tile;

  // Minimum over the four neighbours of the swept tile, west/east/north/south.
  always_comb begin
    have = 1'b0;
    best = '0;
    nt   = '0;
    if (r_q > 0) begin
      nt = t_q - TW'(MeshCols);
      if (cvalid_q[nt] && (!have || cost_q[nt] < best)) begin best = cost_q[nt]; have = 1'b1; end
    end
    if (int'(r_q) < MeshRows - 1) begin
      nt = t_q + TW'(MeshCols);
      if (cvalid_q[nt] && (!have || cost_q[nt] < best)) begin best = cost_q[nt]; have = 1'b1; end
    end
    if (c_q > 0) begin
      nt = t_q - TW'(1);
      if (cvalid_q[nt] && (!have || cost_q[nt] < best)) begin best = cost_q[nt]; have = 1'b1; end
    end
    if (int'(c_q) < MeshCols - 1) begin
      nt = t_q + TW'(1);
      if (cvalid_q[nt] && (!have || cost_q[nt] < best)) begin best = cost_q[nt]; have = 1'b1; end
    end
    cand = sat_add(CostBits'(load_q[t_q]), best);
    upd  = have && (!cvalid_q[t_q] || cost_q[t_q] > cand);
  end

  // Final port choice from the router's own neighbours.
  always_comb begin
    // Row of the router tile by comparing against each row start.
    xr = '0;
    for (int r = 1; r < int'(MeshRows); r++) begin
      if (int'(router_tile_i[TW-1:0]) >= r * int'(MeshCols)) xr = RW'(r);
    end
    xc = CW'(router_tile_i[TW-1:0] - TW'(int'(xr) * int'(MeshCols)));
    p_have = 1'b0;
    p_best = '0;
    p_sel  = PortLocal;
    pnt    = '0;
    if (xr > 0) begin
      pnt = router_tile_i[TW-1:0] - TW'(MeshCols);
      if (cvalid_q[pnt] && (!p_have || cost_q[pnt] < p_best)) begin
        p_best = cost_q[pnt]; p_sel = PortWest; p_have = 1'b1;
      end
    end
    if (int'(xr) < MeshRows - 1) begin
      pnt = router_tile_i[TW-1:0] + TW'(MeshCols);
      if (cvalid_q[pnt] && (!p_have || cost_q[pnt] < p_best)) begin
        p_best = cost_q[pnt]; p_sel = PortEast; p_have = 1'b1;
      end
    end
    if (xc > 0) begin
      pnt = router_tile_i[TW-1:0] - TW'(1);
      if (cvalid_q[pnt] && (!p_have || cost_q[pnt] < p_best)) begin
        p_best = cost_q[pnt]; p_sel = PortNorth; p_have = 1'b1;
      end
    end
    if (int'(xc) < MeshCols - 1) begin
      pnt = router_tile_i[TW-1:0] + TW'(1);
      if (cvalid_q[pnt] && (!p_have || cost_q[pnt] < p_best)) begin
        p_best = cost_q[pnt]; p_sel = PortSouth; p_have = 1'b1;
      end
    end
  end

  assign lv_sat = (int'(cmd_i.load_value) > int'(LoadMax)) ? LoadMax
                                                            : LoadBits'(cmd_i.load_value);
  assign route_ok = (int'(cmd_i.dest_tile) < Tiles) && (int'(router_tile_i) < Tiles) &&
                    (cmd_i.dest_tile != router_tile_i);
  assign last_tile = int'(t_q) == Tiles - 1;

  always_comb begin
    state_d   = state_q;
    cmd_pop_o = 1'b0;
    case (state_q)
      StIdle: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.kind == KindLoad) state_d = StIdle;
          else if (route_ok) state_d = StInit;
          else state_d = StOut;
        end
      end
      StInit:  state_d = StSweep;
      StSweep: if (last_tile && !(changed_q || upd)) state_d = StPick;
      StPick:  state_d = StOut;
      StOut:   if (res_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  assign res_valid_o = state_q == StOut;
  assign next_port_o = port_q;
  assign path_cost_o = pcost_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      for (int i = 0; i < Tiles; i++) load_q[i] <= '0;
      cvalid_q  <= '0;
      t_q       <= '0;
      r_q       <= '0;
      c_q       <= '0;
      changed_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        StIdle: begin
          if (!cmd_empty_i && cmd_i.kind == KindLoad && int'(cmd_i.load_tile) < Tiles) begin
            load_q[cmd_i.load_tile[TW-1:0]] <= lv_sat;
          end
        end
        StInit: begin
          // Only the destination starts with a known cost.
          cvalid_q <= Tiles'(1) << dest_q;
          t_q <= '0; r_q <= '0; c_q <= '0;
          changed_q <= 1'b0;
        end
        StSweep: begin
          if (upd) cvalid_q[t_q] <= 1'b1;
          if (last_tile) begin
            t_q <= '0; r_q <= '0; c_q <= '0;
            changed_q <= 1'b0;
          end else begin
            t_q <= t_q + TW'(1);
            if (int'(c_q) == MeshCols - 1) begin
              c_q <= '0; r_q <= r_q + RW'(1);
            end else begin
              c_q <= c_q + CW'(1);
            end
            changed_q <= changed_q | upd;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && !cmd_empty_i) begin
      dest_q  <= cmd_i.dest_tile[TW-1:0];
      port_q  <= PortLocal;
      pcost_q <= '0;
    end
    if (state_q == StInit) cost_q[dest_q] <= '0;
    if (state_q == StSweep && upd) cost_q[t_q] <= cand;
    if (state_q == StPick) begin
      port_q  <= p_have ? p_sel : PortLocal;
      pcost_q <= p_have ? p_best : '0;
    end
  end
endmodule

>>> rtl/congestion_aware_mesh_router_core.sv
// Top level of the congestion-aware mesh router: front queue plus relaxation engine.
// Usage: items enter through push/full; an item is taken when push is high and
// full low. kind_i 0 writes a tile's load (no result); kind_i 1 requests a route to
// dest_tile_i and yields one result word. Results leave through empty/pop, with
// next_port_o and path_cost_o valid while empty is low.
// The user must write router_tile via cfg_we_i/cfg_wdata_i while the block is idle;
// the block does not enforce this. A two-word command queue decouples the input
// from the engine: pushes go on during a route or an unpopped result, until full.
// A load update is written as the engine takes it from the queue. A route request
// passes through an init step, then relaxation sweeps over all Tiles tiles, one tile
// per cycle, repeated until a sweep changes nothing (at least 2 and at most about
// Tiles+1 sweeps), then a pick step that chooses the port, before its result is shown.
// Local and out-of-range requests skip the sweeps and go straight to the result.
// Reset clears the load table, the router tile, the queue and the engine state.
// If the receiver stalls, the result holds and the engine waits; the queue then fills.
module congestion_aware_mesh_router_core #(
  parameter int unsigned MeshRows = camr_pkg::MeshRowsDef,
  parameter int unsigned MeshCols = camr_pkg::MeshColsDef,
  parameter int unsigned LoadBits = camr_pkg::LoadBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic        kind_i,
  input  logic [7:0]  load_tile_i,
  input  logic [7:0]  load_value_i,
  input  logic [7:0]  dest_tile_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  next_port_o,
  output logic [15:0] path_cost_o
);
  import camr_pkg::*;

  logic [7:0] router_tile_q;
  cmd_t       in_cmd, q_cmd;
  logic       q_empty, q_pop, res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) router_tile_q <= '0;
    else if (cfg_we_i) router_tile_q <= cfg_wdata_i;
  end

  assign in_cmd = '{kind: kind_i, load_tile: load_tile_i,
                    load_value: load_value_i, dest_tile: dest_tile_i};

  camr_cmd_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i(push), .data_i(in_cmd), .full_o(full),
    .pop_i(q_pop), .empty_o(q_empty), .data_o(q_cmd)
  );

  camr_engine #(.MeshRows(MeshRows), .MeshCols(MeshCols), .LoadBits(LoadBits)) u_engine (
    .clk_i, .rst_ni,
    .router_tile_i(router_tile_q),
    .cmd_empty_i(q_empty), .cmd_i(q_cmd), .cmd_pop_o(q_pop),
    .res_valid_o(res_valid), .res_ready_i(pop),
    .next_port_o, .path_cost_o
  );

  assign empty = !res_valid;
endmodule
